// ===== rtl/max_divisor_count_selector_core_defines.svh =====
// Assertion macros shared by the checker of the divisor count selector.
`ifndef MAX_DIVISOR_COUNT_SELECTOR_CORE_DEFINES_SVH
`define MAX_DIVISOR_COUNT_SELECTOR_CORE_DEFINES_SVH

// Same-cycle implication, ignored while reset is high.
`define MDCS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, ignored while reset is high.
`define MDCS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that also holds across reset.
`define MDCS_ASSERT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/mdcs_pkg.sv =====
// Types, constants and the microcode table of the divisor count selector.
package mdcs_pkg;

  localparam int VALUE_BITS_DEF = 16;
  localparam int OUT_VALUE_BITS = 16;
  localparam int COUNT_BITS     = 8;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = 8'd255;

  localparam int PC_BITS = 3;

  localparam logic [PC_BITS-1:0] STEP_IDLE   = 3'd0;
  localparam logic [PC_BITS-1:0] STEP_TEST   = 3'd1;
  localparam logic [PC_BITS-1:0] STEP_DINIT  = 3'd2;
  localparam logic [PC_BITS-1:0] STEP_DSTEP  = 3'd3;
  localparam logic [PC_BITS-1:0] STEP_ACCUM  = 3'd4;
  localparam logic [PC_BITS-1:0] STEP_FINISH = 3'd5;
  localparam logic [PC_BITS-1:0] STEP_RETURN = 3'd6;

  localparam logic [2:0] COND_NEVER       = 3'd0;
  localparam logic [2:0] COND_ALWAYS      = 3'd1;
  localparam logic [2:0] COND_IN_WAIT     = 3'd2;
  localparam logic [2:0] COND_SQ_GT_V     = 3'd3;
  localparam logic [2:0] COND_BIT_MORE    = 3'd4;
  localparam logic [2:0] COND_OUT_BLOCKED = 3'd5;

  typedef struct packed {
    logic [VALUE_BITS_DEF-1:0] value;
    logic                      last;
  } item_t;

  typedef struct packed {
    logic [OUT_VALUE_BITS-1:0] best_value;
    logic [COUNT_BITS-1:0]     best_count;
  } result_t;

  typedef struct packed {
    logic [2:0]         cond;
    logic [PC_BITS-1:0] target;
    logic               ld_item;
    logic               div_init;
    logic               div_step;
    logic               accum;
    logic               finish;
  } ctrl_t;

  typedef struct packed {
    logic in_wait;
    logic sq_gt_v;
    logic bit_more;
    logic out_blocked;
  } status_t;

  function automatic ctrl_t ucode(input logic [PC_BITS-1:0] pc);
    ctrl_t w;
    w = '0;
    case (pc)
      STEP_IDLE: begin
        w.cond    = COND_IN_WAIT;
        w.target  = STEP_IDLE;
        w.ld_item = 1'b1;
      end
      STEP_TEST: begin
        w.cond   = COND_SQ_GT_V;
        w.target = STEP_FINISH;
      end
      STEP_DINIT: begin
        w.div_init = 1'b1;
      end
      STEP_DSTEP: begin
        w.cond     = COND_BIT_MORE;
        w.target   = STEP_DSTEP;
        w.div_step = 1'b1;
      end
      STEP_ACCUM: begin
        w.cond   = COND_ALWAYS;
        w.target = STEP_TEST;
        w.accum  = 1'b1;
      end
      STEP_FINISH: begin
        w.cond   = COND_OUT_BLOCKED;
        w.target = STEP_FINISH;
        w.finish = 1'b1;
      end
      STEP_RETURN: begin
        w.cond   = COND_ALWAYS;
        w.target = STEP_IDLE;
      end
      default: begin
        w.cond   = COND_ALWAYS;
        w.target = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/mdcs_sequencer.sv =====
// Step counter and microcode table that drive the datapath.
module mdcs_sequencer import mdcs_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  status_t status,
  output ctrl_t   ctrl
);

  logic [PC_BITS-1:0] pc;
  logic [PC_BITS-1:0] pc_next;
  logic               take;

  assign ctrl = ucode(pc);

  always_comb begin
    case (ctrl.cond)
      COND_NEVER:       take = 1'b0;
      COND_ALWAYS:      take = 1'b1;
      COND_IN_WAIT:     take = status.in_wait;
      COND_SQ_GT_V:     take = status.sq_gt_v;
      COND_BIT_MORE:    take = status.bit_more;
      COND_OUT_BLOCKED: take = status.out_blocked;
      default:          take = 1'b1;
    endcase
    pc_next = take ? ctrl.target : pc + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= STEP_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

// ===== rtl/mdcs_datapath.sv =====
// Trial divisor, square, bit-serial remainder, count and best-value registers.
module mdcs_datapath import mdcs_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  ctrl_t   ctrl,
  input  logic    item_valid,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result,
  output status_t status
);

  localparam int VALUE_BITS = VALUE_BITS_DEF;
  localparam int IW = (VALUE_BITS + 1) / 2 + 1;
  localparam int SW = VALUE_BITS + 2;
  localparam int BW = $clog2(VALUE_BITS);

  logic [VALUE_BITS-1:0] val;
  logic                  last_r;
  logic [IW-1:0]         idx;
  logic [SW-1:0]         sq;
  logic [IW-1:0]         rem;
  logic [BW-1:0]         bitidx;
  logic [COUNT_BITS-1:0] cnt;
  logic [COUNT_BITS-1:0] top_count;
  logic [VALUE_BITS-1:0] top_value;
  logic                  seen;

  logic                  accept;
  logic [IW:0]           trial;
  logic [IW:0]           diff;
  logic                  ge;
  logic [IW-1:0]         rem_next;
  logic                  sq_eq;
  logic [COUNT_BITS:0]   cnt_sum;
  logic [COUNT_BITS-1:0] cnt_sat;
  logic                  wins;
  logic [COUNT_BITS-1:0] win_count;
  logic [VALUE_BITS-1:0] win_value;

  assign accept   = item_valid & ctrl.ld_item;
  assign trial    = {rem, val[bitidx]};
  assign diff     = trial - {1'b0, idx};
  assign ge       = trial >= {1'b0, idx};
  assign rem_next = ge ? diff[IW-1:0] : trial[IW-1:0];
  assign sq_eq    = sq == {2'b00, val};
  assign cnt_sum  = {1'b0, cnt} + (sq_eq ? 9'd1 : 9'd2);
  assign cnt_sat  = cnt_sum[COUNT_BITS] ? COUNT_MAX : cnt_sum[COUNT_BITS-1:0];

  assign wins = !seen || (cnt > top_count) || ((cnt == top_count) && (val > top_value));
  assign win_count = wins ? cnt : top_count;
  assign win_value = wins ? val : top_value;

  assign status.in_wait     = !item_valid;
  assign status.sq_gt_v     = sq > {2'b00, val};
  assign status.bit_more    = bitidx != '0;
  assign status.out_blocked = result_valid & !result_ready & last_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      val    <= VALUE_BITS'(item.value);
      last_r <= item.last;
      idx    <= IW'(1);
      sq     <= SW'(1);
      cnt    <= '0;
    end
    if (ctrl.div_init) begin
      rem    <= '0;
      bitidx <= BW'(VALUE_BITS - 1);
    end
    if (ctrl.div_step) begin
      rem    <= rem_next;
      bitidx <= bitidx - 1'b1;
    end
    if (ctrl.accum) begin
      if (rem == '0) begin
        cnt <= cnt_sat;
      end
      idx <= idx + 1'b1;
      sq  <= sq + SW'({idx, 1'b1});
    end
    if (ctrl.finish && !status.out_blocked) begin
      top_count <= win_count;
      top_value <= win_value;
      if (last_r) begin
        result.best_value <= OUT_VALUE_BITS'(win_value);
        result.best_count <= win_count;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen         <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      if (ctrl.finish && !status.out_blocked) begin
        seen <= !last_r;
        if (last_r) begin
          result_valid <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/max_divisor_count_selector_core.sv =====
// Top level of the divisor count selector: sequencer and datapath.
// Each word tries divisors from 1 up to the integer square root of the value, one after another:
// each trial divisor runs one remainder bit per cycle through the shared shift-subtract unit.
// One word is in work at a time; after its last trial the result word waits in its own register.
// Synchronous reset clears the step counter, the seen flag of the running best and the result valid flag.
module max_divisor_count_selector_core import mdcs_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_ready,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  ctrl_t   ctrl;
  status_t status;

  mdcs_sequencer u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  mdcs_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .item_valid   (item_valid),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .status       (status)
  );

  assign item_ready = ctrl.ld_item & !rst;

endmodule

// ===== rtl/mdcs_checker.sv =====
// Port-level checks of the divisor count selector and their binding.
`include "max_divisor_count_selector_core_defines.svh"

module mdcs_checker import mdcs_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    item_valid,
  input logic    item_ready,
  input item_t   item,
  input logic    result_valid,
  input logic    result_ready,
  input result_t result
);

  logic in_take;
  logic out_stall;
  logic out_named;

  assign in_take   = item_valid && item_ready;
  assign out_stall = result_valid && !result_ready;
  assign out_named = result_valid && result.best_value != '0;

  `MDCS_ASSERT_NEXT(a_result_hold, out_stall, result_valid && $stable(result), "result not held")
  `MDCS_ASSERT_ALWAYS(a_reset_clear, rst, !result_valid, "result valid after reset")
  `MDCS_ASSERT_NEXT(a_one_at_a_time, in_take, !item_ready, "second word taken while busy")
  `MDCS_ASSERT_NOW(a_count_nonzero, out_named, result.best_count != '0, "winner with zero count")

endmodule

bind max_divisor_count_selector_core mdcs_checker u_chk (.*);

// ===== tb/tb_top.sv =====
// Self-checking testbench for the divisor count selector: directed and random sets checked against a predictor.
module tb_top;
  import mdcs_pkg::*;

  localparam int IDLE_LIMIT   = 25000;
  localparam int DRAIN_CYCLES = 5000;
  localparam int RANDOM_WORDS = 120;

  class winner_board;
    logic [COUNT_BITS-1:0]     top_count;
    logic [OUT_VALUE_BITS-1:0] top_value;
    bit                        seen_any;
    result_t                   pending_winners[$];
    int                        errors;

    function new();
      clear_set();
      errors = 0;
    endfunction

    function void clear_set();
      top_count = '0;
      top_value = '0;
      seen_any  = 1'b0;
    endfunction

    function logic [COUNT_BITS-1:0] divisor_tally(logic [VALUE_BITS_DEF-1:0] v);
      int unsigned n;
      int unsigned d;
      int unsigned c;
      n = 32'(v);
      c = 0;
      for (d = 1; d * d <= n; d++) begin
        if (n % d == 0) begin
          c += (d * d == n) ? 1 : 2;
        end
      end
      if (c > COUNT_MAX) begin
        c = COUNT_MAX;
      end
      return COUNT_BITS'(c);
    endfunction

    function void note_word(item_t w);
      logic [COUNT_BITS-1:0] cnt;
      result_t               r;
      cnt = divisor_tally(w.value);
      if (!seen_any || cnt > top_count || (cnt == top_count && w.value > top_value)) begin
        top_count = cnt;
        top_value = w.value;
      end
      seen_any = 1'b1;
      if (w.last) begin
        r.best_value = top_value;
        r.best_count = top_count;
        pending_winners.push_back(r);
        clear_set();
      end
    endfunction

    function void report(string what, int want, int got);
      errors++;
      if (errors <= 10) begin
        $display("mismatch on %s: expected %0d, got %0d", what, want, got);
      end
    endfunction

    function void check_word(result_t got);
      result_t want;
      if (pending_winners.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("unexpected result word: value %0d, count %0d",
                   got.best_value, got.best_count);
        end
      end else begin
        want = pending_winners.pop_front();
        if (got.best_value !== want.best_value) begin
          report("best_value", int'(want.best_value), int'(got.best_value));
        end
        if (got.best_count !== want.best_count) begin
          report("best_count", int'(want.best_count), int'(got.best_count));
        end
      end
    endfunction
  endclass

  logic    clk = 1'b0;
  logic    rst;
  logic    item_valid;
  logic    item_ready;
  item_t   item;
  logic    result_valid;
  logic    result_ready;
  result_t result;

  winner_board board;
  bit          steady;
  int          idle_cycles;

  always #10 clk = ~clk;

  max_divisor_count_selector_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (item_valid && item_ready) begin
        board.note_word(item);
      end
      if (result_valid && result_ready) begin
        board.check_word(result);
      end
      if ((item_valid && item_ready) || (result_valid && result_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("FAIL max_divisor_count_selector_core");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic send_word(input logic [VALUE_BITS_DEF-1:0] v, input logic l);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item       <= '{value: v, last: l};
    item_valid <= 1'b1;
    do @(posedge clk); while (!item_ready);
    @(negedge clk);
  endtask

  task automatic pause_for_results();
    item_valid <= 1'b0;
    do @(negedge clk); while (board.pending_winners.size() != 0);
  endtask

  function automatic logic [VALUE_BITS_DEF-1:0] pick_value();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel <= 5) begin
      return VALUE_BITS_DEF'($urandom_range(0, 1023));
    end else if (sel <= 7) begin
      return VALUE_BITS_DEF'($urandom_range(0, 65535));
    end else if (sel == 8) begin
      case ($urandom_range(0, 7))
        0: return 16'd0;
        1: return 16'd1;
        2: return 16'd65535;
        3: return 16'd55440;
        4: return 16'd65521;
        5: return 16'd65025;
        6: return 16'd45360;
        default: return 16'd32768;
      endcase
    end
    return VALUE_BITS_DEF'($urandom_range(0, 255));
  endfunction

  initial begin
    int stall;
    result_ready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 6);
      if (stall != 0) begin
        result_ready <= 1'b0;
        if ($urandom_range(0, 1) == 1) begin
          do @(posedge clk); while (!result_valid);
          @(negedge clk);
        end
        repeat (stall) @(negedge clk);
      end
      result_ready <= 1'b1;
      do @(posedge clk); while (!result_valid);
      @(negedge clk);
    end
  end

  initial begin
    int sent;
    int len;
    int sets;
    board      = new();
    rst        = 1'b1;
    item_valid = 1'b0;
    item       = '0;
    steady     = 1'b0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    send_word(16'd1, 1'b1);
    send_word(16'd0, 1'b1);
    send_word(16'd0, 1'b0);
    send_word(16'd0, 1'b1);
    send_word(16'd0, 1'b0);
    send_word(16'd1, 1'b1);
    send_word(16'd65535, 1'b0);
    send_word(16'd55440, 1'b1);
    send_word(16'd10, 1'b0);
    send_word(16'd6, 1'b0);
    send_word(16'd8, 1'b1);
    send_word(16'd2, 1'b0);
    send_word(16'd65521, 1'b1);
    send_word(16'd65025, 1'b0);
    send_word(16'd4, 1'b0);
    send_word(16'd1, 1'b1);
    send_word(16'd32768, 1'b0);
    send_word(16'd16, 1'b0);
    send_word(16'd36, 1'b1);
    send_word(16'd12, 1'b0);
    send_word(16'd0, 1'b1);
    pause_for_results();

    sent = 0;
    sets = 0;
    while (sent < RANDOM_WORDS) begin
      steady = ($urandom_range(0, 4) == 0);
      len    = $urandom_range(1, 6);
      for (int k = 0; k < len; k++) begin
        send_word(pick_value(), k == len - 1);
      end
      sent += len;
      sets++;
      if (sets % 8 == 0) begin
        pause_for_results();
      end
    end

    pause_for_results();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (board.errors == 0 && board.pending_winners.size() == 0) begin
      $display("PASS max_divisor_count_selector_core");
    end else begin
      $display("FAIL max_divisor_count_selector_core");
    end
    $finish;
  end

endmodule
